[rtl/core/rsaep_pkg.sv]
package rsaep_pkg;

   localparam int KEY_BITS    = 28;
   localparam int BYTE_BITS   = 8;
   localparam int DIGIT_BITS  = 7;
   localparam int DIGIT_COUNT = 4;
   localparam int DIGIT_IDX_BITS = $clog2(DIGIT_COUNT);
   localparam int MUL_CNT_BITS   = $clog2(KEY_BITS);

   localparam logic [DIGIT_IDX_BITS-1:0] DIGIT_LAST = DIGIT_IDX_BITS'(DIGIT_COUNT - 1);
   localparam logic [MUL_CNT_BITS-1:0]   MUL_LAST   = MUL_CNT_BITS'(KEY_BITS - 1);

   localparam logic [KEY_BITS-1:0] EXPONENT_RESET = KEY_BITS'(0);
   localparam logic [KEY_BITS-1:0] MODULUS_RESET  = KEY_BITS'(2);

   typedef enum logic {
      CSR_EXPONENT = 1'b0,
      CSR_MODULUS  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BASE_GO,
      S_BASE_WAIT,
      S_STEP,
      S_MUL_WAIT,
      S_SQR_GO,
      S_SQR_WAIT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [KEY_BITS-1:0] a;
      logic [KEY_BITS-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic                done;
      logic [KEY_BITS-1:0] product;
   } mul_sts_type;

   typedef struct packed {
      logic                load;
      logic [KEY_BITS-1:0] value;
      logic                chunk_end;
   } tx_cmd_type;

endpackage

[rtl/core/rsaep_if.sv]
interface rsaep_req_if
   import rsaep_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] plain_byte;
   logic                 chunk_end;

   modport source (output valid, output plain_byte, output chunk_end, input ready);
   modport sink   (input valid, input plain_byte, input chunk_end, output ready);
endinterface

interface rsaep_rsp_if
   import rsaep_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [DIGIT_BITS-1:0] cipher_digit;
   logic                  last_digit;
   logic                  chunk_end_out;

   modport source (output valid, output cipher_digit, output last_digit,
                   output chunk_end_out, input ready);
   modport sink   (input valid, input cipher_digit, input last_digit,
                   input chunk_end_out, output ready);
endinterface

[rtl/core/rsaep_mulmod.sv]
module rsaep_mulmod
   import rsaep_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [KEY_BITS-1:0] modulus,
   input  mul_cmd_type         cmd,
   output mul_sts_type         sts
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [KEY_BITS-1:0]     a_ff, a_in;
   logic [KEY_BITS-1:0]     b_ff, b_in;
   logic [KEY_BITS-1:0]     acc_ff, acc_in;

   logic [KEY_BITS+1:0]     sum;
   logic [KEY_BITS+2:0]     diff1;
   logic [KEY_BITS+2:0]     diff2;
   logic [KEY_BITS-1:0]     reduced;

   // one bit of b per cycle, msb first: acc = 2*acc + b_i*a mod m
   always_comb begin
      sum   = {acc_ff, 1'b0} + (b_ff[KEY_BITS-1] ? {2'b00, a_ff} : '0);
      diff1 = {1'b0, sum} - {3'b000, modulus};
      diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
      if (!diff2[KEY_BITS+2]) begin
         reduced = diff2[KEY_BITS-1:0];
      end else if (!diff1[KEY_BITS+2]) begin
         reduced = diff1[KEY_BITS-1:0];
      end else begin
         reduced = sum[KEY_BITS-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = MUL_LAST;
         a_in    = cmd.a;
         b_in    = cmd.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = reduced;
         b_in   = {b_ff[KEY_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - MUL_CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign sts.done    = done_ff;
   assign sts.product = acc_ff;

endmodule

[rtl/core/rsaep_digit_tx.sv]
module rsaep_digit_tx
   import rsaep_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  tx_cmd_type         cmd,
   output logic               busy,
   rsaep_rsp_if.source        rsp_ch
);

   logic                      valid_ff, valid_in;
   logic [DIGIT_IDX_BITS-1:0] idx_ff, idx_in;
   logic [KEY_BITS-1:0]       val_ff, val_in;
   logic                      end_ff, end_in;
   logic                      last;

   assign last = (idx_ff == DIGIT_LAST);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      end_in   = end_ff;
      if (cmd.load && !valid_ff) begin
         valid_in = 1'b1;
         idx_in   = '0;
         val_in   = cmd.value;
         end_in   = cmd.chunk_end;
      end else if (valid_ff && rsp_ch.ready) begin
         val_in = val_ff >> DIGIT_BITS;
         idx_in = idx_ff + DIGIT_IDX_BITS'(1);
         if (last) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      idx_ff <= idx_in;
      val_ff <= val_in;
      end_ff <= end_in;
   end

   assign busy                 = valid_ff;
   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.cipher_digit  = val_ff[DIGIT_BITS-1:0];
   assign rsp_ch.last_digit    = last;
   assign rsp_ch.chunk_end_out = last & end_ff;

endmodule

[rtl/core/rsa_encrypt_pack7_core.sv]
// Encrypts one plaintext byte per request as byte^exponent mod modulus and returns the
// 28-bit ciphertext as four 7-bit digits, least significant first; the fourth digit
// carries last_digit and the request's chunk_end. Exponent and modulus are written through
// the csr port (index 0 and 1) only while the block is idle, a rule the user must keep:
// the block itself does not enforce it. A modulus below 2 gives zero. Every modular
// product runs through one bit-serial multiplier. A request first reduces the byte,
// then squares once per exponent bit up to its highest set bit, multiplying once more
// per set bit, and finally hands the ciphertext over to the digit transmitter.
// A new request is taken while the previous ciphertext digits are still being delivered.
module rsa_encrypt_pack7_core
   import rsaep_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [KEY_BITS-1:0] csr_wdata,
   rsaep_req_if.sink           req_ch,
   rsaep_rsp_if.source         rsp_ch
);

   state_type            state_ff, state_in;
   logic [KEY_BITS-1:0]  exponent_ff, modulus_ff;
   logic [KEY_BITS-1:0]  ex_ff, ex_in;
   logic [KEY_BITS-1:0]  acc_ff, acc_in;
   logic [KEY_BITS-1:0]  sq_ff, sq_in;
   logic [BYTE_BITS-1:0] byte_ff, byte_in;
   logic                 end_ff, end_in;
   logic                 bad_ff, bad_in;

   mul_cmd_type          mul_cmd;
   mul_sts_type          mul_sts;
   tx_cmd_type           tx_cmd;
   logic                 tx_busy;
   logic                 accept;

   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= EXPONENT_RESET;
         modulus_ff  <= MODULUS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPONENT: exponent_ff <= csr_wdata;
            CSR_MODULUS:  modulus_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_BASE_GO;
         end
         S_BASE_GO: state_in = S_BASE_WAIT;
         S_BASE_WAIT: begin
            if (mul_sts.done) state_in = S_STEP;
         end
         S_STEP: begin
            if (ex_ff == '0) begin
               if (!tx_busy) state_in = S_IDLE;
            end else if (ex_ff[0]) begin
               state_in = S_MUL_WAIT;
            end else begin
               state_in = S_SQR_GO;
            end
         end
         S_MUL_WAIT: begin
            if (mul_sts.done) state_in = S_SQR_GO;
         end
         S_SQR_GO: state_in = S_SQR_WAIT;
         S_SQR_WAIT: begin
            if (mul_sts.done) state_in = S_STEP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready    = 1'b0;
      mul_cmd.start   = 1'b0;
      mul_cmd.a       = sq_ff;
      mul_cmd.b       = sq_ff;
      tx_cmd.load     = 1'b0;
      tx_cmd.value    = bad_ff ? '0 : acc_ff;
      tx_cmd.chunk_end = end_ff;
      case (state_ff)
         S_IDLE: req_ch.ready = 1'b1;
         S_BASE_GO: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = KEY_BITS'(1);
            mul_cmd.b     = KEY_BITS'(byte_ff);
         end
         S_STEP: begin
            if (ex_ff == '0) begin
               tx_cmd.load = !tx_busy;
            end else if (ex_ff[0]) begin
               mul_cmd.start = 1'b1;
               mul_cmd.a     = acc_ff;
            end
         end
         S_SQR_GO: mul_cmd.start = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      ex_in   = ex_ff;
      acc_in  = acc_ff;
      sq_in   = sq_ff;
      byte_in = byte_ff;
      end_in  = end_ff;
      bad_in  = bad_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               byte_in = req_ch.plain_byte;
               end_in  = req_ch.chunk_end;
               bad_in  = (modulus_ff < MODULUS_RESET);
               ex_in   = (modulus_ff < MODULUS_RESET) ? '0 : exponent_ff;
            end
         end
         S_BASE_WAIT: begin
            if (mul_sts.done) begin
               sq_in  = mul_sts.product;
               acc_in = KEY_BITS'(1);
            end
         end
         S_MUL_WAIT: begin
            if (mul_sts.done) acc_in = mul_sts.product;
         end
         S_SQR_WAIT: begin
            if (mul_sts.done) begin
               sq_in = mul_sts.product;
               ex_in = ex_ff >> 1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ex_ff   <= ex_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
      bad_ff  <= bad_in;
   end

   rsaep_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .cmd     (mul_cmd),
      .sts     (mul_sts)
   );

   rsaep_digit_tx u_digit_tx (
      .clock  (clock),
      .reset  (reset),
      .cmd    (tx_cmd),
      .busy   (tx_busy),
      .rsp_ch (rsp_ch)
   );

endmodule
